[hw/rtl/clock_calendar_with_alarms_unit_assert.svh]
// assertion macros used by the checker file of the clock calendar unit
// no dependencies; included by bare file name
`ifndef CLOCK_CALENDAR_WITH_ALARMS_UNIT_ASSERT_SVH
`define CLOCK_CALENDAR_WITH_ALARMS_UNIT_ASSERT_SVH

// property checked at every rising edge, switched off while reset is high
`define CCAL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every rising edge, reset included
`define CCAL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/ccal_pkg.sv]
// types, codes and constants of the clock calendar unit
// no dependencies; used by the interface, the top level and the checker
package ccal_pkg;

   typedef enum logic [2:0] {
      KIND_TICK       = 3'd0,
      KIND_SET_TIME   = 3'd1,
      KIND_SET_DATE   = 3'd2,
      KIND_SET_ALARM  = 3'd3,
      KIND_TOGGLE     = 3'd4,
      KIND_SILENCE    = 3'd5,
      KIND_RESTART    = 3'd6
   } kind_type;

   localparam logic [1:0] RING_NONE = 2'd0;
   localparam logic [1:0] RING_ONE  = 2'd1;
   localparam logic [1:0] RING_TWO  = 2'd2;

   localparam logic [4:0]  RESET_DAY        = 5'd21;
   localparam logic [3:0]  RESET_MONTH      = 4'd6;
   localparam logic [13:0] RESET_YEAR       = 14'd2020;
   localparam logic [6:0]  RESET_YEAR_MOD100 = 7'd20;
   localparam logic [1:0]  RESET_CENTURY_MOD4 = 2'd0;
   localparam logic [13:0] YEAR_MAX         = 14'd9999;

   typedef struct packed {
      logic [2:0] kind;
      logic       alarm_index;
      logic [4:0] set_hour;
      logic [5:0] set_minute;
      logic [3:0] set_month;
      logic [4:0] set_day;
   } req_payload_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [4:0]  display_hour;
      logic        pm;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [1:0]  ringing;
   } rsp_payload_type;

   function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month)
         4'd2: begin
            days = leap ? 5'd29 : 5'd28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            days = 5'd30;
         end
         default: begin
            days = 5'd31;
         end
      endcase
      return days;
   endfunction

endpackage

[hw/rtl/ccal_stream_if.sv]
// valid/ready stream channel carrying one payload struct
// payload type comes from ccal_pkg at instantiation
interface ccal_stream_if #(
   parameter type payload_type = ccal_pkg::req_payload_type
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/clock_calendar_with_alarms_unit.sv]
// a req transfer passes the input register, then the result register, before it shows up as a rsp
// throughput: one item per cycle while rsp is not stalled; all carry, calendar and alarm logic is combinational
// back-pressure on rsp stalls the result register, the input register keeps one more item
// reset (synchronous, active high): time 00:00:00, date 21.06.2020, alarms cleared and off,
// alarm allowed, 24-hour mode, both channel registers empty
module clock_calendar_with_alarms_unit (
   input  logic                 clock,
   input  logic                 reset,
   ccal_stream_if.sink          req_chan,
   ccal_stream_if.source        rsp_chan,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data
);

   // input register
   logic                      s1_valid_ff;
   ccal_pkg::req_payload_type s1_data_ff;

   // result register
   logic                      rsp_valid_ff;
   ccal_pkg::rsp_payload_type rsp_data_ff;
   ccal_pkg::rsp_payload_type rsp_data_in;

   // time and date
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [4:0]  day_ff, day_in;
   logic [3:0]  month_ff, month_in;
   logic [13:0] year_ff, year_in;
   // year modulo 100 and century modulo 4 follow the year so the leap test needs no divider
   logic [6:0]  year_mod100_ff, year_mod100_in;
   logic [1:0]  century_ff, century_in;

   // alarms
   logic [4:0]  alarm_hour_ff [2];
   logic [4:0]  alarm_hour_in [2];
   logic [5:0]  alarm_min_ff  [2];
   logic [5:0]  alarm_min_in  [2];
   logic [1:0]  alarm_en_ff, alarm_en_in;
   logic        allowed_ff, allowed_in;

   // display mode, cleared by a restart item as well
   logic        twelve_ff, twelve_in;

   logic        out_free;
   logic        s1_fire;

   // handshake: the result register drains when empty or taken, the input register
   // moves on into it and can refill in the same cycle
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_fire        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // event, carry normalization and alarm evaluation for the item in the input register
   always_comb begin
      logic [6:0]  sec_p;
      logic [6:0]  min_p;
      logic [5:0]  hour_p;
      logic [5:0]  day_p;
      logic [3:0]  month_p;
      logic [13:0] year_p;
      logic [6:0]  mod100_p;
      logic [1:0]  century_p;
      logic [5:0]  ahour_p [2];
      logic [6:0]  amin_p  [2];
      logic        allowed_p;
      logic        leap;
      logic [4:0]  dim;
      logic [1:0]  match;
      logic [1:0]  ring;

      sec_p       = {1'b0, sec_ff};
      min_p       = {1'b0, min_ff};
      hour_p      = {1'b0, hour_ff};
      day_p       = {1'b0, day_ff};
      month_p     = month_ff;
      year_p      = year_ff;
      mod100_p    = year_mod100_ff;
      century_p   = century_ff;
      ahour_p[0]  = {1'b0, alarm_hour_ff[0]};
      ahour_p[1]  = {1'b0, alarm_hour_ff[1]};
      amin_p[0]   = {1'b0, alarm_min_ff[0]};
      amin_p[1]   = {1'b0, alarm_min_ff[1]};
      alarm_en_in = alarm_en_ff;
      allowed_p   = allowed_ff;
      twelve_in   = csr_write_enable ? csr_write_data : twelve_ff;

      case (ccal_pkg::kind_type'(s1_data_ff.kind))
         ccal_pkg::KIND_TICK: begin
            sec_p = sec_p + 7'd1;
         end
         ccal_pkg::KIND_SET_TIME: begin
            // seconds are kept
            hour_p = {1'b0, s1_data_ff.set_hour};
            min_p  = {1'b0, s1_data_ff.set_minute};
         end
         ccal_pkg::KIND_SET_DATE: begin
            // out-of-range month or day zero drops the whole command
            if (s1_data_ff.set_month >= 4'd1 && s1_data_ff.set_month <= 4'd12
                && s1_data_ff.set_day != 5'd0) begin
               month_p = s1_data_ff.set_month;
               day_p   = {1'b0, s1_data_ff.set_day};
            end
         end
         ccal_pkg::KIND_SET_ALARM: begin
            ahour_p[s1_data_ff.alarm_index] = {1'b0, s1_data_ff.set_hour};
            amin_p[s1_data_ff.alarm_index]  = {1'b0, s1_data_ff.set_minute};
         end
         ccal_pkg::KIND_TOGGLE: begin
            // any key press silences
            alarm_en_in[s1_data_ff.alarm_index] = !alarm_en_ff[s1_data_ff.alarm_index];
            allowed_p = 1'b0;
         end
         ccal_pkg::KIND_SILENCE: begin
            allowed_p = 1'b0;
         end
         ccal_pkg::KIND_RESTART: begin
            sec_p       = 7'd0;
            min_p       = 7'd0;
            hour_p      = 6'd0;
            day_p       = {1'b0, ccal_pkg::RESET_DAY};
            month_p     = ccal_pkg::RESET_MONTH;
            year_p      = ccal_pkg::RESET_YEAR;
            mod100_p    = ccal_pkg::RESET_YEAR_MOD100;
            century_p   = ccal_pkg::RESET_CENTURY_MOD4;
            ahour_p[0]  = 6'd0;
            ahour_p[1]  = 6'd0;
            amin_p[0]   = 7'd0;
            amin_p[1]   = 7'd0;
            alarm_en_in = 2'b00;
            allowed_p   = 1'b1;
            twelve_in   = 1'b0;
         end
         default: begin
            // unused kind leaves the state alone
         end
      endcase

      // single carry ripple: seconds, minutes, hours, day, month, year
      if (sec_p >= 7'd60) begin
         sec_p = sec_p - 7'd60;
         min_p = min_p + 7'd1;
      end
      if (min_p >= 7'd60) begin
         min_p  = min_p - 7'd60;
         hour_p = hour_p + 6'd1;
      end
      if (hour_p >= 6'd24) begin
         hour_p = hour_p - 6'd24;
         day_p  = day_p + 6'd1;
      end

      // gregorian leap rule from the tracked remainders
      leap = (year_p[1:0] == 2'd0 && mod100_p != 7'd0)
             || (mod100_p == 7'd0 && century_p == 2'd0);
      dim  = ccal_pkg::days_in_month(month_p, leap);

      if (day_p > {1'b0, dim}) begin
         day_p   = 6'd1;
         month_p = month_p + 4'd1;
      end
      if (month_p > 4'd12) begin
         month_p = 4'd1;
         // year saturates at its top value
         if (year_p < ccal_pkg::YEAR_MAX) begin
            year_p = year_p + 14'd1;
            if (mod100_p == 7'd99) begin
               mod100_p  = 7'd0;
               century_p = century_p + 2'd1;
            end else begin
               mod100_p = mod100_p + 7'd1;
            end
         end
      end

      // alarm times: minute carry, then one hour wrap
      for (int i = 0; i < 2; i++) begin
         if (amin_p[i] >= 7'd60) begin
            amin_p[i]  = amin_p[i] - 7'd60;
            ahour_p[i] = ahour_p[i] + 6'd1;
         end
         if (ahour_p[i] >= 6'd24) begin
            ahour_p[i] = ahour_p[i] - 6'd24;
         end
         alarm_hour_in[i] = ahour_p[i][4:0];
         alarm_min_in[i]  = amin_p[i][5:0];
      end

      sec_in         = sec_p[5:0];
      min_in         = min_p[5:0];
      hour_in        = hour_p[4:0];
      day_in         = day_p[4:0];
      month_in       = month_p;
      year_in        = year_p;
      year_mod100_in = mod100_p;
      century_in     = century_p;

      // alarm one wins over alarm two; allowed comes back once nothing matches
      for (int i = 0; i < 2; i++) begin
         match[i] = alarm_en_in[i] && alarm_hour_in[i] == hour_in
                    && alarm_min_in[i] == min_in;
      end
      if (match[0] && allowed_p) begin
         ring = ccal_pkg::RING_ONE;
      end else if (match[1] && allowed_p) begin
         ring = ccal_pkg::RING_TWO;
      end else begin
         ring = ccal_pkg::RING_NONE;
      end
      allowed_in = (match == 2'b00) ? 1'b1 : allowed_p;

      rsp_data_in.hour         = hour_in;
      rsp_data_in.display_hour = (twelve_in && hour_in >= 5'd12) ? hour_in - 5'd12 : hour_in;
      rsp_data_in.pm           = twelve_in && hour_in >= 5'd12;
      rsp_data_in.minute       = min_in;
      rsp_data_in.second       = sec_in;
      rsp_data_in.day          = day_in;
      rsp_data_in.month        = month_in;
      rsp_data_in.year         = year_in;
      rsp_data_in.ringing      = ring;
   end

   // channel control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_data_ff <= req_chan.payload;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // clock, calendar and alarm state moves once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff           <= 6'd0;
         min_ff           <= 6'd0;
         hour_ff          <= 5'd0;
         day_ff           <= ccal_pkg::RESET_DAY;
         month_ff         <= ccal_pkg::RESET_MONTH;
         year_ff          <= ccal_pkg::RESET_YEAR;
         year_mod100_ff   <= ccal_pkg::RESET_YEAR_MOD100;
         century_ff       <= ccal_pkg::RESET_CENTURY_MOD4;
         alarm_hour_ff[0] <= 5'd0;
         alarm_hour_ff[1] <= 5'd0;
         alarm_min_ff[0]  <= 6'd0;
         alarm_min_ff[1]  <= 6'd0;
         alarm_en_ff      <= 2'b00;
         allowed_ff       <= 1'b1;
         twelve_ff        <= 1'b0;
      end else if (s1_fire) begin
         sec_ff           <= sec_in;
         min_ff           <= min_in;
         hour_ff          <= hour_in;
         day_ff           <= day_in;
         month_ff         <= month_in;
         year_ff          <= year_in;
         year_mod100_ff   <= year_mod100_in;
         century_ff       <= century_in;
         alarm_hour_ff[0] <= alarm_hour_in[0];
         alarm_hour_ff[1] <= alarm_hour_in[1];
         alarm_min_ff[0]  <= alarm_min_in[0];
         alarm_min_ff[1]  <= alarm_min_in[1];
         alarm_en_ff      <= alarm_en_in;
         allowed_ff       <= allowed_in;
         twelve_ff        <= twelve_in;
      end else begin
         // csr writes are to come only while no item is in flight; the block itself does not enforce it
         twelve_ff <= csr_write_enable ? csr_write_data : twelve_ff;
      end
   end

endmodule

[hw/rtl/ccal_checker.sv]
// port-level checks on the result channel of the clock calendar unit
// depends on ccal_pkg and clock_calendar_with_alarms_unit_assert.svh; bound to the top level
`include "clock_calendar_with_alarms_unit_assert.svh"

module ccal_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input ccal_pkg::rsp_payload_type rsp_payload
);

   // a stalled result holds
   `CCAL_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "rsp changed while stalled")

   // reset empties the result side
   `CCAL_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // every shown time and date is normalized
   `CCAL_ASSERT(a_rsp_range, clock, reset, rsp_valid |-> rsp_payload.hour < 5'd24 && rsp_payload.minute < 6'd60 && rsp_payload.second < 6'd60 && rsp_payload.day != 5'd0 && rsp_payload.month != 4'd0 && rsp_payload.month <= 4'd12 && rsp_payload.year <= 14'd9999 && rsp_payload.ringing != 2'd3, "rsp field out of range")

   // pm mark and display hour agree with the 24-hour count
   `CCAL_ASSERT(a_rsp_pm, clock, reset, rsp_valid && rsp_payload.pm |-> rsp_payload.hour >= 5'd12 && rsp_payload.display_hour == rsp_payload.hour - 5'd12, "pm display hour mismatch")

   `CCAL_ASSERT(a_rsp_no_pm, clock, reset, rsp_valid && !rsp_payload.pm |-> rsp_payload.display_hour == rsp_payload.hour, "display hour mismatch")

endmodule

bind clock_calendar_with_alarms_unit ccal_checker u_ccal_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

[test/tb_top.sv]
// testbench for clock_calendar_with_alarms_unit: a scoreboard class predicts every reading
// depends on ccal_pkg and ccal_stream_if from the rtl folder
// plain tasks drive events and the twelve-hour register; an always block drives the reading back-pressure
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ccal_pkg::*;

   // kind code outside the defined events, the block must leave all state alone
   localparam logic [2:0] KIND_UNUSED = 3'd7;

   // random events per phase of the random part, six phases in all
   localparam int PHASE_EVENTS = 130;

   // new-year rollovers walked by the loop of the calendar part
   localparam int YEAR_STEPS = 6;

   // calendar scoreboard: own copy of the clock, calendar and alarm state,
   // one expected reading queued per accepted event
   class calendar_scoreboard;
      int unsigned     sec, mins, hrs, day, mon, yr;
      int unsigned     alarm_hr[2];
      int unsigned     alarm_min[2];
      bit              alarm_on[2];
      bit              alarm_allowed;
      bit              twelve_hour;
      rsp_payload_type expected_readings[$];
      int              mismatches;

      function new();
         mismatches = 0;
         restore();
      endfunction

      function void restore();
         sec = 0;
         mins = 0;
         hrs = 0;
         day = 32'(RESET_DAY);
         mon = 32'(RESET_MONTH);
         yr = 32'(RESET_YEAR);
         for (int i = 0; i < 2; i++) begin
            alarm_hr[i] = 0;
            alarm_min[i] = 0;
            alarm_on[i] = 1'b0;
         end
         alarm_allowed = 1'b1;
         twelve_hour = 1'b0;
      endfunction

      function int unsigned month_length(int unsigned m, int unsigned y);
         bit leap;
         leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
         if (m == 2) return leap ? 29 : 28;
         if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
         return 31;
      endfunction

      function void apply_event(req_payload_type p);
         bit              hit_one, hit_two;
         logic [1:0]      ring;
         rsp_payload_type e;
         case (p.kind)
            KIND_TICK: begin
               sec++;
            end
            KIND_SET_TIME: begin
               hrs = 32'(p.set_hour);
               mins = 32'(p.set_minute);
            end
            KIND_SET_DATE: begin
               if (p.set_month >= 1 && p.set_month <= 12 && p.set_day >= 1) begin
                  mon = 32'(p.set_month);
                  day = 32'(p.set_day);
               end
            end
            KIND_SET_ALARM: begin
               alarm_hr[p.alarm_index] = 32'(p.set_hour);
               alarm_min[p.alarm_index] = 32'(p.set_minute);
            end
            KIND_TOGGLE: begin
               alarm_on[p.alarm_index] = !alarm_on[p.alarm_index];
               alarm_allowed = 1'b0;
            end
            KIND_SILENCE: begin
               alarm_allowed = 1'b0;
            end
            KIND_RESTART: begin
               restore();
            end
            default: begin
            end
         endcase
         // one carry step per unit, as in the block
         if (sec >= 60) begin
            sec -= 60;
            mins++;
         end
         if (mins >= 60) begin
            mins -= 60;
            hrs++;
         end
         if (hrs >= 24) begin
            hrs -= 24;
            day++;
         end
         if (day > month_length(mon, yr)) begin
            day = 1;
            mon++;
         end
         if (mon > 12) begin
            mon = 1;
            if (yr < YEAR_MAX) yr++;
         end
         for (int i = 0; i < 2; i++) begin
            if (alarm_min[i] >= 60) begin
               alarm_min[i] -= 60;
               alarm_hr[i]++;
            end
            if (alarm_hr[i] >= 24) alarm_hr[i] -= 24;
         end
         hit_one = alarm_on[0] && alarm_hr[0] == hrs && alarm_min[0] == mins;
         hit_two = alarm_on[1] && alarm_hr[1] == hrs && alarm_min[1] == mins;
         ring = RING_NONE;
         if (hit_one && alarm_allowed) ring = RING_ONE;
         else if (hit_two && alarm_allowed) ring = RING_TWO;
         if (!hit_one && !hit_two) alarm_allowed = 1'b1;
         e.hour = 5'(hrs);
         e.display_hour = 5'(twelve_hour ? hrs % 12 : hrs);
         e.pm = twelve_hour && hrs >= 12;
         e.minute = 6'(mins);
         e.second = 6'(sec);
         e.day = 5'(day);
         e.month = 4'(mon);
         e.year = 14'(yr);
         e.ringing = ring;
         expected_readings.push_back(e);
      endfunction

      function void compare_field(string name, logic [13:0] want, logic [13:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_reading(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_readings.size() == 0) begin
            $display("%0t: reading with nothing expected, actual %p", $time, got);
            mismatches++;
            return;
         end
         want = expected_readings.pop_front();
         compare_field("hour", 14'(want.hour), 14'(got.hour));
         compare_field("display_hour", 14'(want.display_hour), 14'(got.display_hour));
         compare_field("pm", 14'(want.pm), 14'(got.pm));
         compare_field("minute", 14'(want.minute), 14'(got.minute));
         compare_field("second", 14'(want.second), 14'(got.second));
         compare_field("day", 14'(want.day), 14'(got.day));
         compare_field("month", 14'(want.month), 14'(got.month));
         compare_field("year", want.year, got.year);
         compare_field("ringing", 14'(want.ringing), 14'(got.ringing));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic csr_write_data = 1'b0;

   ccal_stream_if #(.payload_type(req_payload_type)) req_if ();
   ccal_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   calendar_scoreboard sb = new();

   int items_sent = 0;
   int stall_left = 0;
   // set during some phases so both sides run back to back for a while
   bit idle_free = 1'b0;

   clock_calendar_with_alarms_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // reading side: after each transfer ready drops while a random stall count runs down
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // every reading transfer is checked against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         sb.check_reading(rsp_if.payload);
         stall_left <= idle_free ? 0 : $urandom_range(0, 5);
      end
   end

   // hard stop in case the block hangs
   initial begin
      #20_000_000;
      $display("clock_calendar_with_alarms_unit test failed");
      $finish;
   end

   // one event transfer: optional gap with valid low, then hold valid until ready
   task automatic send_item(input req_payload_type p);
      int gap;
      gap = idle_free ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.payload <= p;
      do @(posedge clock); while (!req_if.ready);
      sb.apply_event(p);
      items_sent++;
   endtask

   // fields the kind does not use carry random bits
   task automatic send_cmd(input logic [2:0] kind, input int idx, input int h, input int m,
                           input int mo, input int d);
      req_payload_type p;
      p.kind = kind;
      p.alarm_index = 1'($urandom_range(0, 1));
      p.set_hour = 5'($urandom_range(0, 31));
      p.set_minute = 6'($urandom_range(0, 63));
      p.set_month = 4'($urandom_range(0, 15));
      p.set_day = 5'($urandom_range(0, 31));
      case (kind)
         KIND_SET_TIME: begin
            p.set_hour = 5'(h);
            p.set_minute = 6'(m);
         end
         KIND_SET_ALARM: begin
            p.set_hour = 5'(h);
            p.set_minute = 6'(m);
            p.alarm_index = 1'(idx);
         end
         KIND_SET_DATE: begin
            p.set_month = 4'(mo);
            p.set_day = 5'(d);
         end
         KIND_TOGGLE: begin
            p.alarm_index = 1'(idx);
         end
         default: begin
         end
      endcase
      send_item(p);
   endtask

   task automatic send_tick();
      send_cmd(KIND_TICK, 0, 0, 0, 0, 0);
   endtask

   // drop valid and let every expected reading come out before touching the register
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (sb.expected_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input bit twelve);
      wait_idle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= twelve;
      @(posedge clock);
      sb.twelve_hour = twelve;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // arm an alarm, reach its time either by setting it or by ticking into the minute,
   // then let it ring, silence it or switch it off
   task automatic alarm_scenario();
      int idx, h, m, tries;
      idx = $urandom_range(0, 1);
      h = $urandom_range(0, 23);
      m = $urandom_range(0, 59);
      send_cmd(KIND_SET_ALARM, idx, h, m, 0, 0);
      // sometimes both alarms share the time so priority shows
      if ($urandom_range(0, 3) == 0) begin
         send_cmd(KIND_SET_ALARM, 1 - idx, h, m, 0, 0);
         if (!sb.alarm_on[1 - idx]) send_cmd(KIND_TOGGLE, 1 - idx, 0, 0, 0, 0);
      end
      if (!sb.alarm_on[idx]) send_cmd(KIND_TOGGLE, idx, 0, 0, 0, 0);
      if ($urandom_range(0, 2) == 0) begin
         send_cmd(KIND_SET_TIME, 0, (m == 0) ? (h + 23) % 24 : h, (m + 59) % 60, 0, 0);
         tries = 0;
         while (sb.mins != m && tries < 61) begin
            send_tick();
            tries++;
         end
      end else begin
         send_cmd(KIND_SET_TIME, 0, h, m, 0, 0);
      end
      repeat ($urandom_range(0, 6)) send_tick();
      if ($urandom_range(0, 1) == 1) begin
         send_cmd(KIND_SILENCE, 0, 0, 0, 0, 0);
         repeat ($urandom_range(0, 3)) send_tick();
      end
      if ($urandom_range(0, 2) == 0) send_cmd(KIND_TOGGLE, idx, 0, 0, 0, 0);
   endtask

   task automatic random_step();
      int r;
      int edge_months[4] = '{1, 2, 4, 12};
      r = $urandom_range(0, 99);
      if (r < 40) begin
         send_tick();
      end else if (r < 50) begin
         send_cmd(KIND_SET_TIME, 0, $urandom_range(0, 31), $urandom_range(0, 63), 0, 0);
      end else if (r < 54) begin
         send_cmd(KIND_SET_DATE, 0, 0, 0, $urandom_range(0, 15), $urandom_range(0, 31));
      end else if (r < 58) begin
         // month ends, leap day included
         send_cmd(KIND_SET_DATE, 0, 0, 0, edge_months[$urandom_range(0, 3)],
                  $urandom_range(28, 31));
      end else if (r < 66) begin
         send_cmd(KIND_SET_ALARM, $urandom_range(0, 1), $urandom_range(0, 31),
                  $urandom_range(0, 63), 0, 0);
      end else if (r < 72) begin
         send_cmd(KIND_TOGGLE, $urandom_range(0, 1), 0, 0, 0, 0);
      end else if (r < 76) begin
         send_cmd(KIND_SILENCE, 0, 0, 0, 0, 0);
      end else if (r < 78) begin
         send_cmd(KIND_RESTART, 0, 0, 0, 0, 0);
      end else if (r < 80) begin
         send_cmd(KIND_UNUSED, 0, 0, 0, 0, 0);
      end else begin
         alarm_scenario();
      end
   endtask

   // walk a few new-year rollovers, leap days checked on the way
   task automatic climb_years();
      for (int y = 0; y < YEAR_STEPS; y++) begin
         if (sb.yr % 4 == 0) send_cmd(KIND_SET_DATE, 0, 0, 0, 2, 29);
         send_cmd(KIND_SET_DATE, 0, 0, 0, 12, 31);
         // minute 60 carries into hour 24, which carries into the next day
         send_cmd(KIND_SET_TIME, 0, 23, 60, 0, 0);
      end
      // one rollover by ticks, one by an oversized set time
      send_cmd(KIND_SET_DATE, 0, 0, 0, 12, 31);
      send_cmd(KIND_SET_TIME, 0, 23, 59, 0, 0);
      while (sb.mon == 12) send_tick();
      send_cmd(KIND_SET_DATE, 0, 0, 0, 12, 31);
      send_cmd(KIND_SET_TIME, 0, 31, 63, 0, 0);
   endtask

   initial begin
      int goal;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part in twelve-hour mode
      write_mode(1'b1);
      send_tick();
      send_cmd(KIND_SET_TIME, 0, 31, 63, 0, 0);      // largest field values, carry into next day
      send_cmd(KIND_SET_TIME, 0, 0, 0, 0, 0);        // midnight
      send_cmd(KIND_SET_TIME, 0, 23, 59, 0, 0);
      send_cmd(KIND_SET_TIME, 0, 12, 0, 0, 0);       // noon, pm boundary
      send_cmd(KIND_SET_DATE, 0, 0, 0, 0, 5);        // month zero is dropped
      send_cmd(KIND_SET_DATE, 0, 0, 0, 13, 10);      // month past december is dropped
      send_cmd(KIND_SET_DATE, 0, 0, 0, 15, 31);
      send_cmd(KIND_SET_DATE, 0, 0, 0, 3, 0);        // day zero is dropped
      send_cmd(KIND_SET_DATE, 0, 0, 0, 2, 29);       // leap day of the reset year
      send_cmd(KIND_SET_DATE, 0, 0, 0, 2, 30);       // overflows into march
      send_cmd(KIND_SET_DATE, 0, 0, 0, 4, 31);       // overflows into may
      send_cmd(KIND_SET_DATE, 0, 0, 0, 12, 31);
      send_cmd(KIND_SET_ALARM, 0, 31, 63, 0, 0);     // alarm fields wrap
      send_cmd(KIND_SET_ALARM, 1, 23, 60, 0, 0);
      send_cmd(KIND_TOGGLE, 0, 0, 0, 0, 0);
      send_cmd(KIND_TOGGLE, 1, 0, 0, 0, 0);
      send_cmd(KIND_SET_TIME, 0, 8, 3, 0, 0);        // alarm one rings
      send_cmd(KIND_SET_ALARM, 1, 8, 3, 0, 0);       // both match, alarm one wins
      send_cmd(KIND_TOGGLE, 0, 0, 0, 0, 0);          // key press silences alarm two
      send_tick();
      send_cmd(KIND_SET_TIME, 0, 8, 4, 0, 0);        // no match re-arms
      send_cmd(KIND_SET_TIME, 0, 8, 3, 0, 0);        // alarm two rings
      send_cmd(KIND_SILENCE, 0, 0, 0, 0, 0);
      send_cmd(KIND_UNUSED, 0, 0, 0, 0, 0);
      send_cmd(KIND_RESTART, 0, 0, 0, 0, 0);         // also drops twelve-hour mode

      // random part, mode alternating per phase, two phases without idling
      for (int phase = 0; phase < 6; phase++) begin
         idle_free = (phase == 2 || phase == 4);
         write_mode(1'(phase % 2));
         goal = items_sent + PHASE_EVENTS;
         while (items_sent < goal) random_step();
      end

      idle_free = 1'b0;
      write_mode(1'b1);
      climb_years();
      write_mode(1'b0);
      repeat (20) random_step();

      wait_idle();
      repeat (6) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("clock_calendar_with_alarms_unit test passed");
      end else begin
         $display("clock_calendar_with_alarms_unit test failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ccal_pkg.sv
hw/rtl/ccal_stream_if.sv
hw/rtl/clock_calendar_with_alarms_unit.sv
hw/rtl/ccal_checker.sv
test/tb_top.sv
